// ===== hw/rtl/upd_pkg.sv =====
package upd_pkg;

	// special characters of the encoding
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// configuration space
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_PLUS_AS_SPACE = 1'b0;
	localparam logic PLUS_AS_SPACE_RST = 1'b1;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int MAX_RESULTS     = 3;

	// lookahead held by the front
	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_PCT,
		HELD_DIGIT
	} upd_held_t;

	// one classified word: up to three output bytes
	typedef struct packed {
		logic [1:0]                         cnt;
		logic [MAX_RESULTS-1:0][7:0]        data;
		logic                               last;
	} upd_entry_t;

	typedef struct packed {
		logic       valid;
		upd_entry_t entry;
	} upd_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} upd_qstat_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, b[3:0]};
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/upd_ifs.sv =====
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink (input valid, out_byte, out_last, output ready);
endinterface

// ===== hw/rtl/upd_front.sv =====
module upd_front
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        plus_as_space,
	upd_in_if.sink      enc,
	input  upd_qstat_t  qstat,
	output upd_push_t   push
);

	upd_held_t  held_q, held_d;
	logic [7:0] digit_q, digit_d;
	logic [4:0] hx, hx_held;
	logic       is_hex, p_hold, accept;
	logic [7:0] p_byte;
	upd_entry_t ent;

	assign enc.ready = !qstat.full;
	assign accept    = enc.valid && enc.ready;

	always_comb begin
		hx      = hex_decode(enc.in_byte);
		hx_held = hex_decode(digit_q);
		is_hex  = hx[4];
		// byte handled with nothing held
		p_hold  = (enc.in_byte == CH_PERCENT) && !enc.in_last;
		p_byte  = (enc.in_byte == CH_PLUS && plus_as_space) ? CH_SPACE : enc.in_byte;
		ent     = '0;
		held_d  = held_q;
		digit_d = digit_q;
		case (held_q)
			HELD_NONE: begin
				if (p_hold) begin
					held_d = HELD_PCT;
				end else begin
					ent.cnt     = 2'd1;
					ent.data[0] = p_byte;
				end
			end
			HELD_PCT: begin
				if (is_hex && !enc.in_last) begin
					held_d  = HELD_DIGIT;
					digit_d = enc.in_byte;
				end else begin
					held_d      = HELD_NONE;
					ent.data[0] = CH_PERCENT;
					if (is_hex) begin
						ent.cnt     = 2'd2;
						ent.data[1] = enc.in_byte;
					end else if (p_hold) begin
						ent.cnt = 2'd1;
						held_d  = HELD_PCT;
					end else begin
						ent.cnt     = 2'd2;
						ent.data[1] = p_byte;
					end
				end
			end
			HELD_DIGIT: begin
				held_d = HELD_NONE;
				if (is_hex) begin
					ent.cnt     = 2'd1;
					ent.data[0] = {hx_held[3:0], hx[3:0]};
				end else begin
					ent.data[0] = CH_PERCENT;
					ent.data[1] = digit_q;
					if (p_hold) begin
						ent.cnt = 2'd2;
						held_d  = HELD_PCT;
					end else begin
						ent.cnt     = 2'd3;
						ent.data[2] = p_byte;
					end
				end
			end
			default: begin
				held_d = HELD_NONE;
			end
		endcase
		// end of string flushes the lookahead
		if (enc.in_last) begin
			held_d = HELD_NONE;
		end
		ent.last = enc.in_last;
	end

	assign push.valid = accept && (ent.cnt != 2'd0);
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			digit_q <= digit_d;
		end
	end

endmodule

// ===== hw/rtl/upd_queue.sv =====
module upd_queue
	import upd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  upd_push_t   push,
	input  logic        pop,
	output upd_entry_t  head,
	output upd_qstat_t  qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	upd_entry_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem[rd_ptr_q];
	assign do_pop      = pop && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.entry;
		end
	end

endmodule

// ===== hw/rtl/upd_back.sv =====
module upd_back
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  upd_entry_t  head,
	input  upd_qstat_t  qstat,
	output logic        pop,
	upd_out_if.source   dec
);

	logic [1:0] pos_q;
	logic       valid_q, last_q;
	logic [7:0] byte_q;
	logic       load, sending, final_byte;

	assign load       = !valid_q || dec.ready;
	assign sending    = load && !qstat.empty;
	assign final_byte = (pos_q == head.cnt - 2'd1);
	assign pop        = sending && final_byte;

	assign dec.valid    = valid_q;
	assign dec.out_byte = byte_q;
	assign dec.out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= !qstat.empty;
			end
			if (sending) begin
				pos_q <= final_byte ? 2'd0 : pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sending) begin
			byte_q <= head.data[pos_q];
			last_q <= head.last && final_byte;
		end
	end

endmodule

// ===== hw/rtl/url_percent_decoder.sv =====
// path: a word that yields output is written into the queue, then its first decoded byte
//   moves into the output register; throughput: one input word per cycle while each yields
//   at most one byte and dec.ready holds; the output register sends one byte per cycle unless
//   stalled, so words that yield two or three bytes fill the queue and the input stalls once it is full
// reset: arst_n asynchronous, active low; clears lookahead, queue and output; plus_as_space = 1
module url_percent_decoder
	import upd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	upd_in_if.sink            enc,
	upd_out_if.source         dec,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// configuration register
	logic       plus_as_space_q;
	logic       cfg_wr;

	// front to queue, queue to back
	upd_push_t  push;
	upd_entry_t head;
	upd_qstat_t qstat;
	logic       pop;

	// register index sits above the byte offset; index 0 only
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PLUS_AS_SPACE);
	assign prdata = (paddr[2] == REG_PLUS_AS_SPACE) ?
		{{(DATA_W-1){1'b0}}, plus_as_space_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_as_space_q <= PLUS_AS_SPACE_RST;
		end else if (cfg_wr) begin
			plus_as_space_q <= pwdata[0];
		end
	end

	// front: classifies each byte against the held lookahead, one queue word per input
	// that produces output (escape start and first digit produce none)
	upd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.plus_as_space (plus_as_space_q),
		.enc           (enc),
		.qstat         (qstat),
		.push          (push)
	);

	// short queue decouples the front from output backpressure
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// back: serializes up to three bytes of the head word into the output register
	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.dec    (dec)
	);

	// a last byte always produces output, so it must reach the queue
	ap_last_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(enc.valid && enc.ready && enc.in_last) |-> push.valid)
		else $error("last word accepted without a queue push");

	// queue words are never empty
	ap_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (push.entry.cnt != 2'd0))
		else $error("queue word with no bytes");

	// the front must never write into a full queue
	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !qstat.full)
		else $error("push into full queue");

endmodule
